@@ rtl/core/lamp_pattern_sequencer_top_defines.svh @@
// Assertion macros used by the checker module of the lamp sequencer.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef LAMP_PATTERN_SEQUENCER_TOP_DEFINES_SVH
`define LAMP_PATTERN_SEQUENCER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/lps_pkg.sv @@
package lps_pkg;

	localparam int OpW       = 2;
	localparam int ReqModeW  = 3;
	localparam int ModeW     = 2;
	localparam int DutyW     = 8;
	localparam int TimeW     = 16;
	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 16;
	localparam int WalkIdxW  = 3;
	localparam int WalkCntW  = WalkIdxW + 1;

	localparam int WalkStepsDefault = 7;

	localparam logic [DutyW-1:0] BrightnessReset     = 8'd255;
	localparam logic [TimeW-1:0] StrobeOnReset       = 16'd200;
	localparam logic [TimeW-1:0] StrobeOffReset      = 16'd200;
	localparam logic [TimeW-1:0] WalkIntervalReset   = 16'd1000;
	localparam logic [TimeW-1:0] ElapsedMax          = 16'hFFFF;

	typedef enum logic [OpW-1:0] {
		OP_TICK     = 2'd0,
		OP_SET_MODE = 2'd1,
		OP_NEXT     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [ModeW-1:0] {
		MODE_OFF    = 2'd0,
		MODE_STROBE = 2'd1,
		MODE_WALK   = 2'd2,
		MODE_STEADY = 2'd3
	} mode_t;

	typedef enum logic [CfgIndexW-1:0] {
		CFG_BRIGHTNESS    = 2'd0,
		CFG_STROBE_ON     = 2'd1,
		CFG_STROBE_OFF    = 2'd2,
		CFG_WALK_INTERVAL = 2'd3
	} cfg_index_t;

	localparam logic [ReqModeW-1:0] ReqModeMax = 3'd3;

	function automatic logic [DutyW-1:0] walk_duty(input logic [WalkIdxW-1:0] idx);
		logic [DutyW-1:0] d;
		case (idx)
			3'd0:    d = 8'd10;
			3'd1:    d = 8'd40;
			3'd2:    d = 8'd60;
			3'd3:    d = 8'd100;
			3'd4:    d = 8'd150;
			3'd5:    d = 8'd200;
			default: d = 8'd255;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/core/lps_if.sv @@
interface lps_cmd_if import lps_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OpW-1:0]      op;
	logic [ReqModeW-1:0] new_mode;

	modport source (output valid, output op, output new_mode, input ready);
	modport sink (input valid, input op, input new_mode, output ready);
endinterface

interface lps_status_if import lps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DutyW-1:0] duty;
	logic             lamp_on;
	logic [ModeW-1:0] mode_now;

	modport source (output valid, output duty, output lamp_on, output mode_now, input ready);
	modport sink (input valid, input duty, input lamp_on, input mode_now, output ready);
endinterface

@@ rtl/core/lamp_pattern_sequencer_top.sv @@
// Status: a command transaction shows its status in the cycle after acceptance.
// Throughput: one command per cycle while the status output is not stalled; the status register
// holds a stalled result while the next command is taken as soon as that result leaves.
// Reset: arst_n clears the mode to off, duty, timer, phase and walk index,
// and returns the configuration registers to their default values.
module lamp_pattern_sequencer_top import lps_pkg::*; #(
	parameter int WALK_STEPS = WalkStepsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	lps_cmd_if.sink              cmd,
	lps_status_if.source         status
);

	localparam logic [WalkCntW-1:0] WalkSteps = WalkCntW'(WALK_STEPS);

	logic [DutyW-1:0]    brightness_q;
	logic [TimeW-1:0]    strobe_on_q;
	logic [TimeW-1:0]    strobe_off_q;
	logic [TimeW-1:0]    walk_interval_q;

	mode_t               mode_q, mode_d;
	logic [DutyW-1:0]    duty_q, duty_d;
	logic [TimeW-1:0]    elapsed_q, elapsed_d;
	logic                lit_q, lit_d;
	logic [WalkIdxW-1:0] walk_idx_q, walk_idx_d;
	logic                out_valid_q;

	logic                accept;
	logic [TimeW-1:0]    elapsed_inc;
	logic [TimeW-1:0]    span;
	logic [WalkCntW-1:0] walk_cnt_inc;
	mode_t               req_mode;
	logic                change;

	assign cmd.ready      = !out_valid_q || status.ready;
	assign accept         = cmd.valid && cmd.ready;
	assign status.valid   = out_valid_q;
	assign status.duty    = duty_q;
	assign status.lamp_on = (duty_q != '0);
	assign status.mode_now = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q    <= BrightnessReset;
			strobe_on_q     <= StrobeOnReset;
			strobe_off_q    <= StrobeOffReset;
			walk_interval_q <= WalkIntervalReset;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_BRIGHTNESS:    brightness_q    <= cfg_data[DutyW-1:0];
				CFG_STROBE_ON:     strobe_on_q     <= cfg_data[TimeW-1:0];
				CFG_STROBE_OFF:    strobe_off_q    <= cfg_data[TimeW-1:0];
				CFG_WALK_INTERVAL: walk_interval_q <= cfg_data[TimeW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		elapsed_inc  = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
		span         = lit_q ? strobe_on_q : strobe_off_q;
		walk_cnt_inc = {1'b0, walk_idx_q} + 1'b1;

		if (op_t'(cmd.op) == OP_SET_MODE) begin
			req_mode = (cmd.new_mode > ReqModeMax) ? MODE_OFF : mode_t'(cmd.new_mode[ModeW-1:0]);
		end else begin
			req_mode = mode_t'(mode_q + 1'b1);
		end
		change = (req_mode != mode_q);

		mode_d     = mode_q;
		duty_d     = duty_q;
		elapsed_d  = elapsed_q;
		lit_d      = lit_q;
		walk_idx_d = walk_idx_q;

		case (op_t'(cmd.op))
			OP_TICK: begin
				elapsed_d = elapsed_inc;
				case (mode_q)
					MODE_STROBE: begin
						if (elapsed_inc >= span) begin
							elapsed_d = '0;
							lit_d     = !lit_q;
							duty_d    = lit_q ? '0 : brightness_q;
						end
					end
					MODE_WALK: begin
						if (elapsed_inc >= walk_interval_q) begin
							elapsed_d = '0;
							if (walk_cnt_inc >= WalkSteps) begin
								walk_idx_d = '0;
								duty_d     = '0;
							end else begin
								walk_idx_d = walk_cnt_inc[WalkIdxW-1:0];
								duty_d     = walk_duty(walk_idx_q);
							end
						end
					end
					MODE_STEADY: duty_d = brightness_q;
					default:     duty_d = '0;
				endcase
			end
			OP_SET_MODE, OP_NEXT: begin
				if (change) begin
					mode_d     = req_mode;
					elapsed_d  = '0;
					lit_d      = 1'b0;
					walk_idx_d = '0;
					if (req_mode == MODE_OFF) begin
						duty_d = '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			duty_q      <= '0;
			elapsed_q   <= '0;
			lit_q       <= 1'b0;
			walk_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q     <= mode_d;
				duty_q     <= duty_d;
				elapsed_q  <= elapsed_d;
				lit_q      <= lit_d;
				walk_idx_q <= walk_idx_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (status.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/lps_checker.sv @@
`include "lamp_pattern_sequencer_top_defines.svh"

module lps_checker import lps_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic [OpW-1:0]      cmd_op,
	input logic [ReqModeW-1:0] cmd_new_mode,
	input logic                status_valid,
	input logic                status_ready,
	input logic [DutyW-1:0]    status_duty,
	input logic                status_lamp_on,
	input logic [ModeW-1:0]    status_mode_now
);

	logic cmd_fire;
	logic stalled;
	logic bad_mode_req;

	assign cmd_fire     = cmd_valid && cmd_ready;
	assign stalled      = status_valid && !status_ready;
	assign bad_mode_req = cmd_fire && (op_t'(cmd_op) == OP_SET_MODE) && (cmd_new_mode > ReqModeMax);

	`LPS_ASSERT_NEXT(a_status_holds, stalled, status_valid && $stable(status_duty) && $stable(status_mode_now), "stalled status transaction changed")
	`LPS_ASSERT_SAME(a_lamp_on_match, status_valid, status_lamp_on == (status_duty != '0), "lamp_on disagrees with duty")
	`LPS_ASSERT_SAME(a_off_is_dark, status_valid && (mode_t'(status_mode_now) == MODE_OFF), status_duty == '0, "duty nonzero while mode is off")
	`LPS_ASSERT_NEXT(a_bad_mode_off, bad_mode_req, status_valid && (mode_t'(status_mode_now) == MODE_OFF) && (status_duty == '0), "out-of-range mode request did not select off")

endmodule

bind lamp_pattern_sequencer_top lps_checker u_lps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.cmd_op          (cmd.op),
	.cmd_new_mode    (cmd.new_mode),
	.status_valid    (status.valid),
	.status_ready    (status.ready),
	.status_duty     (status.duty),
	.status_lamp_on  (status.lamp_on),
	.status_mode_now (status.mode_now)
);

@@ tb/sv/testbench.sv @@
module testbench;
	import lps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WalkSteps = WalkStepsDefault;
	localparam int CycleLimit = 400000;
	localparam int PhaseCount = 10;
	localparam int PhaseItems = 75;

	typedef struct packed {
		logic [DutyW-1:0] duty;
		logic             lamp_on;
		mode_t            mode_now;
	} lamp_status_t;

	class lamp_status_board;
		logic [DutyW-1:0] brightness;
		logic [TimeW-1:0] strobe_on;
		logic [TimeW-1:0] strobe_off;
		logic [TimeW-1:0] walk_interval;

		mode_t            mode;
		logic [DutyW-1:0] duty;
		logic [TimeW-1:0] elapsed;
		logic             lit;
		int               walk_pos;

		logic [DutyW-1:0] walk_levels [8];
		lamp_status_t     expected_status [$];
		int unsigned      mismatches;

		function new();
			walk_levels = '{8'd10, 8'd40, 8'd60, 8'd100, 8'd150, 8'd200, 8'd255, 8'd255};
			brightness = 8'd255;
			strobe_on = 16'd200;
			strobe_off = 16'd200;
			walk_interval = 16'd1000;
			mode = MODE_OFF;
			duty = '0;
			elapsed = '0;
			lit = 1'b0;
			walk_pos = 0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [CfgDataW-1:0] data);
			case (idx)
				CFG_BRIGHTNESS:    brightness = data[DutyW-1:0];
				CFG_STROBE_ON:     strobe_on = data[TimeW-1:0];
				CFG_STROBE_OFF:    strobe_off = data[TimeW-1:0];
				CFG_WALK_INTERVAL: walk_interval = data[TimeW-1:0];
				default: ;
			endcase
		endfunction

		function void switch_mode(mode_t m);
			if (m != mode) begin
				mode = m;
				elapsed = '0;
				lit = 1'b0;
				walk_pos = 0;
				if (m == MODE_OFF)
					duty = '0;
			end
		endfunction

		function void advance_ms();
			logic [TimeW-1:0] span;
			if (elapsed != ElapsedMax)
				elapsed = elapsed + 1'b1;
			case (mode)
				MODE_STROBE: begin
					span = lit ? strobe_on : strobe_off;
					if (elapsed >= span) begin
						elapsed = '0;
						lit = ~lit;
						duty = lit ? brightness : '0;
					end
				end
				MODE_WALK: begin
					if (elapsed >= walk_interval) begin
						elapsed = '0;
						duty = walk_levels[walk_pos & 7];
						walk_pos = walk_pos + 1;
						if (walk_pos >= WalkSteps) begin
							walk_pos = 0;
							duty = '0;
						end
					end
				end
				MODE_STEADY: duty = brightness;
				default: duty = '0;
			endcase
		endfunction

		function void note_command(logic [OpW-1:0] op, logic [ReqModeW-1:0] req);
			logic [ModeW-1:0] following;
			lamp_status_t st;
			following = mode + 1'b1;
			case (op_t'(op))
				OP_TICK:     advance_ms();
				OP_SET_MODE: switch_mode(req > ReqModeMax ? MODE_OFF : mode_t'(req[ModeW-1:0]));
				OP_NEXT:     switch_mode(mode_t'(following));
				default: ;
			endcase
			st.duty = duty;
			st.lamp_on = (duty != '0);
			st.mode_now = mode;
			expected_status.push_back(st);
		endfunction

		function void check_status(logic [DutyW-1:0] d, logic on, logic [ModeW-1:0] m);
			lamp_status_t want;
			if (expected_status.size() == 0) begin
				$error("status transaction with no command waiting");
				mismatches++;
			end else begin
				want = expected_status.pop_front();
				if (d !== want.duty) begin
					$error("duty: expected %0d, actual %0d", want.duty, d);
					mismatches++;
				end
				if (on !== want.lamp_on) begin
					$error("lamp_on: expected %0d, actual %0d", want.lamp_on, on);
					mismatches++;
				end
				if (m !== want.mode_now) begin
					$error("mode_now: expected %0d, actual %0d", want.mode_now, m);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected_status.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	lps_cmd_if    cmd_bus ();
	lps_status_if status_bus ();

	lamp_status_board board = new();

	int unsigned cycle_count = 0;
	int          stall_style = 0;
	int          style_left = 0;
	int          stall_phase = 0;

	lamp_pattern_sequencer_top #(
		.WALK_STEPS(WalkSteps)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd_bus),
		.status(status_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("lamp_pattern_sequencer_top regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				board.write_reg(cfg_index_t'(cfg_index), cfg_data);
			if (cmd_bus.valid && cmd_bus.ready)
				board.note_command(cmd_bus.op, cmd_bus.new_mode);
			if (status_bus.valid && status_bus.ready)
				board.check_status(status_bus.duty, status_bus.lamp_on, status_bus.mode_now);
		end
	end

	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 3);
			style_left = $urandom_range(10, 150);
		end else begin
			style_left = style_left - 1;
		end
		stall_phase = stall_phase + 1;
		case (stall_style)
			0: status_bus.ready <= 1'b1;
			1: status_bus.ready <= ($urandom_range(0, 1) == 1);
			2: status_bus.ready <= ($urandom_range(0, 4) == 0);
			default: status_bus.ready <= (stall_phase % 4 != 3);
		endcase
	end

	task automatic put_cmd(op_t op, logic [ReqModeW-1:0] req);
		cmd_bus.valid <= 1'b1;
		cmd_bus.op <= op;
		cmd_bus.new_mode <= req;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
	endtask

	task automatic go_quiet(int cycles);
		cmd_bus.valid <= 1'b0;
		cmd_bus.op <= OpW'($urandom);
		cmd_bus.new_mode <= ReqModeW'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		go_quiet(1);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_regs(logic [DutyW-1:0] level, logic [TimeW-1:0] on_ms,
			logic [TimeW-1:0] off_ms, logic [TimeW-1:0] step_ms);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_BRIGHTNESS;
		cfg_data <= {8'($urandom), level};
		@(posedge clk);
		cfg_index <= CFG_STROBE_ON;
		cfg_data <= on_ms;
		@(posedge clk);
		cfg_index <= CFG_STROBE_OFF;
		cfg_data <= off_ms;
		@(posedge clk);
		cfg_index <= CFG_WALK_INTERVAL;
		cfg_data <= step_ms;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [TimeW-1:0] pick_span();
		if ($urandom_range(0, 3) == 0)
			return TimeW'($urandom_range(9, 40));
		return TimeW'($urandom_range(0, 8));
	endfunction

	task automatic send_random();
		int roll;
		op_t op;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			op = OP_TICK;
		else if (roll < 92)
			op = OP_SET_MODE;
		else if (roll < 97)
			op = OP_NEXT;
		else
			op = OP_NONE;
		put_cmd(op, ReqModeW'($urandom));
	endtask

	task automatic run_phase(int count, bit hold_mid);
		int sent;
		int burst;
		int gap;
		bit held;
		sent = 0;
		held = 1'b0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_random();
				sent++;
			end
			if (hold_mid && !held && sent >= count / 2) begin
				held = 1'b1;
				drain();
			end else begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0)
					go_quiet(gap);
			end
		end
	endtask

	task automatic run_directed();
		put_cmd(OP_TICK, '0);
		put_cmd(OP_NONE, 3'd7);
		put_cmd(OP_SET_MODE, {1'b0, MODE_STEADY});
		put_cmd(OP_TICK, '0);
		put_cmd(OP_NEXT, '0);
		drain();
		program_regs(8'd1, 16'd1, 16'd0, 16'd0);
		put_cmd(OP_SET_MODE, {1'b0, MODE_STROBE});
		repeat (3) put_cmd(OP_TICK, '0);
		put_cmd(OP_SET_MODE, {1'b0, MODE_STROBE});
		put_cmd(OP_NEXT, '0);
		repeat (8) put_cmd(OP_TICK, '0);
		put_cmd(OP_SET_MODE, 3'd5);
		put_cmd(OP_SET_MODE, {1'b0, MODE_WALK});
		put_cmd(OP_SET_MODE, 3'd7);
		put_cmd(OP_NEXT, '0);
		put_cmd(OP_NEXT, '0);
		put_cmd(OP_NEXT, '0);
		put_cmd(OP_TICK, '0);
		put_cmd(OP_NEXT, '0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.op = '0;
		cmd_bus.new_mode = '0;
		status_bus.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < PhaseCount; p++) begin
			drain();
			case (p)
				0: program_regs(8'd255, 16'd0, 16'd0, 16'd0);
				1: program_regs(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				default: program_regs(DutyW'($urandom), pick_span(), pick_span(), pick_span());
			endcase
			run_phase(PhaseItems, p % 3 == 2);
		end
		drain();
		repeat (4) @(posedge clk);
		if (board.mismatches == 0)
			$display("lamp_pattern_sequencer_top regression: pass");
		else
			$display("lamp_pattern_sequencer_top regression: fail");
		$finish;
	end

endmodule
